>>> rtl/gcp_pkg.sv
`timescale 1ns / 1ps
package gcp_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int ANGLE_BITS_DEF   = 32;

  // Internal word width of the CORDIC and the intermediate Q30 values.
  localparam int DW = 40;
  localparam int PC_W = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [DW-1:0] KINV_Q30  = 40'sh00_26DD_3B6A;
  localparam logic signed [DW-1:0] QONE      = 40'sh00_4000_0000;
  localparam logic [31:0]          NEAR_LEN  = 32'd5364662;
  localparam logic signed [DW-1:0] FLAT_BIAS = 40'sd684;
  localparam logic [24:0]          SPEED_K   = 25'd31251423;

  localparam logic [CFG_IDX_W-1:0] REG_START_LAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_LON = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_LAT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_LON   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 3'd5;

  typedef enum logic [3:0] {
    OP_SC, OP_VEC, OP_MULQ, OP_MULRAW, OP_SQRT, OP_SUM, OP_XDIFF, OP_XFLAT,
    OP_DIST, OP_ARRIVE, OP_BRNEAR, OP_JUMP, OP_BRPAST
  } op_t;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_C1, SRC_S1, SRC_C2, SRC_S2, SRC_CD, SRC_SD, SRC_TA, SRC_TB,
    SRC_SV, SRC_Q, SRC_YR, SRC_XR, SRC_DL, SRC_SLAT, SRC_ELAT, SRC_AZ, SRC_D,
    SRC_MAG, SRC_GS, SRC_PHI, SRC_PLO, SRC_SK
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_TA, DST_TB, DST_YR, DST_SQ, DST_P, DST_DA, DST_DB,
    DST_P1, DST_P2, DST_P3, DST_LEN, DST_AZ, DST_LAT, DST_LON
  } dst_t;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    dst_t dst;
  } cmd_t;

  typedef struct packed {
    cmd_t c;
    logic start;
    logic capture;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic near;
    logic past;
  } dp_stat_t;

  // Program labels.
  localparam logic [PC_W-1:0] PC_FAR    = 6'd14;
  localparam logic [PC_W-1:0] PC_AZ     = 6'd19;
  localparam logic [PC_W-1:0] PC_STEP   = 6'd20;
  localparam logic [PC_W-1:0] PC_LON    = 6'd38;
  localparam logic [PC_W-1:0] PC_ARRIVE = 6'd39;

  function automatic cmd_t mk(input op_t op, input src_t a, input src_t b, input dst_t dst);
    cmd_t c;
    c.op = op;
    c.a = a;
    c.b = b;
    c.dst = dst;
    return c;
  endfunction

  function automatic cmd_t prog(input logic [PC_W-1:0] pc);
    cmd_t c;
    case (pc)
      // Track derivation.
      6'd0:  c = mk(OP_SC, SRC_SLAT, SRC_ZERO, DST_P1);
      6'd1:  c = mk(OP_SC, SRC_ELAT, SRC_ZERO, DST_P2);
      6'd2:  c = mk(OP_SC, SRC_DL, SRC_ZERO, DST_P3);
      6'd3:  c = mk(OP_MULQ, SRC_S1, SRC_S2, DST_TA);
      6'd4:  c = mk(OP_MULQ, SRC_C1, SRC_C2, DST_TB);
      6'd5:  c = mk(OP_MULQ, SRC_TB, SRC_CD, DST_TB);
      6'd6:  c = mk(OP_SUM, SRC_TA, SRC_TB, DST_NONE);
      6'd7:  c = mk(OP_MULRAW, SRC_SV, SRC_SV, DST_SQ);
      6'd8:  c = mk(OP_SQRT, SRC_ZERO, SRC_ZERO, DST_NONE);
      6'd9:  c = mk(OP_VEC, SRC_Q, SRC_SV, DST_LEN);
      6'd10: c = mk(OP_BRNEAR, SRC_ZERO, SRC_ZERO, DST_NONE);
      6'd11: c = mk(OP_MULQ, SRC_DL, SRC_C1, DST_YR);
      6'd12: c = mk(OP_XFLAT, SRC_ELAT, SRC_SLAT, DST_NONE);
      6'd13: c = mk(OP_JUMP, SRC_ZERO, SRC_ZERO, DST_NONE);
      6'd14: c = mk(OP_MULQ, SRC_SD, SRC_C2, DST_YR);
      6'd15: c = mk(OP_MULQ, SRC_C1, SRC_S2, DST_TA);
      6'd16: c = mk(OP_MULQ, SRC_S1, SRC_C2, DST_TB);
      6'd17: c = mk(OP_MULQ, SRC_TB, SRC_CD, DST_TB);
      6'd18: c = mk(OP_XDIFF, SRC_TA, SRC_TB, DST_NONE);
      6'd19: c = mk(OP_VEC, SRC_YR, SRC_XR, DST_AZ);
      // Per-item position.
      6'd20: c = mk(OP_MULRAW, SRC_GS, SRC_MAG, DST_P);
      6'd21: c = mk(OP_MULRAW, SRC_PHI, SRC_SK, DST_DA);
      6'd22: c = mk(OP_MULRAW, SRC_PLO, SRC_SK, DST_DB);
      6'd23: c = mk(OP_DIST, SRC_ZERO, SRC_ZERO, DST_NONE);
      6'd24: c = mk(OP_BRPAST, SRC_ZERO, SRC_ZERO, DST_NONE);
      6'd25: c = mk(OP_SC, SRC_AZ, SRC_ZERO, DST_P2);
      6'd26: c = mk(OP_SC, SRC_D, SRC_ZERO, DST_P3);
      6'd27: c = mk(OP_MULQ, SRC_S1, SRC_CD, DST_TA);
      6'd28: c = mk(OP_MULQ, SRC_C1, SRC_SD, DST_TB);
      6'd29: c = mk(OP_MULQ, SRC_TB, SRC_C2, DST_TB);
      6'd30: c = mk(OP_SUM, SRC_TA, SRC_TB, DST_NONE);
      6'd31: c = mk(OP_MULRAW, SRC_SV, SRC_SV, DST_SQ);
      6'd32: c = mk(OP_SQRT, SRC_ZERO, SRC_ZERO, DST_NONE);
      6'd33: c = mk(OP_VEC, SRC_SV, SRC_Q, DST_LAT);
      6'd34: c = mk(OP_MULQ, SRC_S2, SRC_SD, DST_TA);
      6'd35: c = mk(OP_MULQ, SRC_TA, SRC_C1, DST_YR);
      6'd36: c = mk(OP_MULQ, SRC_S1, SRC_SV, DST_TB);
      6'd37: c = mk(OP_XDIFF, SRC_CD, SRC_TB, DST_NONE);
      6'd38: c = mk(OP_VEC, SRC_YR, SRC_XR, DST_LON);
      6'd39: c = mk(OP_ARRIVE, SRC_ZERO, SRC_ZERO, DST_NONE);
      default: c = mk(OP_JUMP, SRC_ZERO, SRC_ZERO, DST_NONE);
    endcase
    return c;
  endfunction

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/great_circle_track_position_top.sv
// Great-circle track position.
// Configuration: a plain write port (cfg_we, cfg_index, cfg_data) sets the start point,
// the end point and the ground speed. Write it only while the block is idle. Any write
// to a known register makes the next item rederive the track azimuth and length.
// Input: one transfer on s_* carries the elapsed seconds of one position request.
// Output: one transfer on m_* carries the position for that request, longitude and
// latitude in binary angle units, and in m_tuser the latched arrival flag.
// Items are worked one at a time by a controller that runs a short microprogram over a
// datapath with one shared iterative CORDIC unit, one multiplier and an iterative
// square root, and the CORDIC calls set the pace. An item past the track end skips the
// position calculation, and the first item after reset or a configuration change first
// runs the track derivation, which takes a shorter path on a short track.
// The result sits in an output register; the next item is accepted while it waits, and
// the block only holds back when a second result is ready and the first is still not
// taken. Reset clears the configuration, the derived track and the output valid.
`timescale 1ns / 1ps
module great_circle_track_position_top
  import gcp_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // [31:0] elapsed_seconds
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata,   // [31:0] cur_lon, [63:32] cur_lat
  output logic                 m_tuser,   // [0] arrived
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] out_lon, out_lat;

  gcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .stat     (stat),
    .cmd      (cmd)
  );

  gcp_datapath #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_data    (s_tdata),
    .out_lon    (out_lon),
    .out_lat    (out_lat),
    .out_arrived(m_tuser)
  );

  assign m_tdata = {out_lat, out_lon};

endmodule

>>> rtl/gcp_cordic.sv
`timescale 1ns / 1ps
module gcp_cordic
  import gcp_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 vec,
  input  logic [31:0]          ang,
  input  logic signed [DW-1:0] xin,
  input  logic signed [DW-1:0] yin,
  output logic                 done,
  output logic signed [DW-1:0] xo,
  output logic signed [DW-1:0] yo,
  output logic [31:0]          zo
);

  localparam int CNTW = $clog2(CORDIC_STEPS);

  logic                 busy;
  logic                 mode;
  logic                 flip;
  logic [CNTW-1:0]      cnt;
  logic signed [DW-1:0] x, y;
  logic signed [33:0]   z;
  logic signed [DW-1:0] dx, dy;
  logic signed [33:0]   za;
  logic                 pos;
  logic [31:0]          a_rot;
  logic                 f_rot;

  always_comb begin
    dx = y >>> 5'(cnt);
    dy = x >>> 5'(cnt);
    za = 34'(atan_val(5'(cnt)));
    // Vectoring steers y toward zero, rotation steers z toward zero.
    pos = mode ? y[DW-1] : !z[33];
    f_rot = ang[31] ^ ang[30];
    a_rot = f_rot ? ang + 32'h80000000 : ang;
  end

  assign xo = (!mode && flip) ? -x : x;
  assign yo = (!mode && flip) ? -y : y;
  assign zo = z[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mode <= vec;
        flip <= 1'b0;
        cnt  <= '0;
        if (!vec) begin
          flip <= f_rot;
          z    <= 34'(signed'(a_rot));
          x    <= KINV_Q30;
          y    <= '0;
          busy <= 1'b1;
        end else if (yin == '0) begin
          z    <= xin[DW-1] ? 34'h080000000 : 34'h0;
          done <= 1'b1;
        end else if (xin == '0) begin
          z    <= yin[DW-1] ? 34'h0C0000000 : 34'h040000000;
          done <= 1'b1;
        end else begin
          x    <= xin[DW-1] ? -xin : xin;
          y    <= xin[DW-1] ? -yin : yin;
          z    <= xin[DW-1] ? 34'h080000000 : 34'h0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (pos) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - za;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + za;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/gcp_isqrt.sv
`timescale 1ns / 1ps
module gcp_isqrt
  import gcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] v,
  output logic        done,
  output logic [30:0] r
);

  logic        busy;
  logic [63:0] rem, res, bitv, trial;

  assign trial = res + bitv;
  assign r = res[30:0];

  // One result bit per step, from the top pair of the radicand down.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= v;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/gcp_datapath.sv
`timescale 1ns / 1ps
module gcp_datapath
  import gcp_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [31:0]          in_data,
  output logic [31:0]          out_lon,
  output logic [31:0]          out_lat,
  output logic                 out_arrived
);

  localparam logic [31:0] ANG_MASK = ~32'h0 << (32 - ANGLE_BITS);

  logic [31:0]          slat, slon, elat, elon;
  logic [15:0]          gs;
  logic [31:0]          tin;
  logic signed [31:0]   c1, s1, c2, s2, cd, sd, sv;
  logic signed [DW-1:0] ta, tb, yr, xr;
  logic [30:0]          q;
  logic [63:0]          sq;
  logic [47:0]          p;
  logic [49:0]          da, db, travel;
  logic [31:0]          len, az, lat, lon;
  logic                 near, arrived;
  logic signed [65:0]   prod;
  logic                 mphase;
  logic                 done;

  logic signed [DW-1:0] va, vb;
  logic signed [32:0]   ma, mb, t33, mag;
  logic [31:0]          dl, dlow;
  logic                 neg;
  logic signed [DW-1:0] qv;
  logic                 c_start, c_done, q_start, q_done;
  logic signed [DW-1:0] c_x, c_y;
  logic [31:0]          c_z, lenc;
  logic signed [31:0]   zs, latc;
  logic [30:0]          q_r;

  function automatic logic signed [31:0] clampq(input logic signed [DW-1:0] v);
    logic signed [31:0] r;
    if (v > QONE) r = 32'(QONE);
    else if (v < -QONE) r = 32'(-QONE);
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [DW-1:0] srcval(input src_t s, input logic [31:0] d_lo,
                                                  input logic signed [32:0] m);
    logic signed [DW-1:0] v;
    unique case (s)
      SRC_C1:   v = DW'(c1);
      SRC_S1:   v = DW'(s1);
      SRC_C2:   v = DW'(c2);
      SRC_S2:   v = DW'(s2);
      SRC_CD:   v = DW'(cd);
      SRC_SD:   v = DW'(sd);
      SRC_TA:   v = ta;
      SRC_TB:   v = tb;
      SRC_SV:   v = DW'(sv);
      SRC_Q:    v = {9'b0, q};
      SRC_YR:   v = yr;
      SRC_XR:   v = xr;
      SRC_DL:   v = DW'(signed'(dl));
      SRC_SLAT: v = DW'(signed'(slat));
      SRC_ELAT: v = DW'(signed'(elat));
      SRC_AZ:   v = {8'b0, az};
      SRC_D:    v = {8'b0, d_lo};
      SRC_MAG:  v = DW'(m);
      SRC_GS:   v = {24'b0, gs};
      SRC_PHI:  v = {16'b0, p[47:24]};
      SRC_PLO:  v = {16'b0, p[23:0]};
      SRC_SK:   v = {15'b0, SPEED_K};
      default:  v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    dl   = elon - slon;
    t33  = {tin[31], tin};
    mag  = t33[32] ? -t33 : t33;
    neg  = tin[31];
    dlow = neg ? -travel[31:0] : travel[31:0];
    va   = srcval(cmd.c.a, dlow, mag);
    vb   = srcval(cmd.c.b, dlow, mag);
    ma   = va[32:0];
    mb   = vb[32:0];
    qv   = DW'(prod >>> 30);
    if (c_z >= 32'hC000_0000) lenc = 32'h0;
    else if (c_z > 32'h8000_0000) lenc = 32'h8000_0000;
    else lenc = c_z;
    zs = signed'(c_z);
    if (zs > 32'sh4000_0000) latc = 32'sh4000_0000;
    else if (zs < -32'sh4000_0000) latc = -32'sh4000_0000;
    else latc = zs;
  end

  assign c_start = cmd.start && (cmd.c.op == OP_SC || cmd.c.op == OP_VEC);
  assign q_start = cmd.start && cmd.c.op == OP_SQRT;

  gcp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(c_start),
    .vec  (cmd.c.op == OP_VEC),
    .ang  (va[31:0]),
    .xin  (vb),
    .yin  (va),
    .done (c_done),
    .xo   (c_x),
    .yo   (c_y),
    .zo   (c_z)
  );

  gcp_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .start(q_start),
    .v    (sq),
    .done (q_done),
    .r    (q_r)
  );

  assign stat.done = done;
  assign stat.near = near;
  assign stat.past = !neg && (travel > {18'b0, len});

  always_ff @(posedge clk) begin
    if (rst) begin
      slat <= '0;
      slon <= '0;
      elat <= '0;
      elon <= '0;
      gs <= '0;
      len <= '0;
      az <= '0;
      near <= 1'b0;
      arrived <= 1'b0;
      mphase <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_START_LAT: slat <= cfg_data;
          REG_START_LON: slon <= cfg_data;
          REG_END_LAT:   elat <= cfg_data;
          REG_END_LON:   elon <= cfg_data;
          REG_SPEED:     gs <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.capture) tin <= in_data;
      if (cmd.load) begin
        out_lon <= lon;
        out_lat <= lat;
        out_arrived <= arrived;
      end
      if (cmd.start) begin
        case (cmd.c.op)
          OP_MULQ, OP_MULRAW: begin
            prod <= ma * mb;
            mphase <= 1'b1;
          end
          OP_SUM: begin
            sv <= clampq(va + vb);
            done <= 1'b1;
          end
          OP_XDIFF: begin
            xr <= va - vb;
            done <= 1'b1;
          end
          OP_XFLAT: begin
            xr <= va - vb + FLAT_BIAS;
            done <= 1'b1;
          end
          OP_DIST: begin
            travel <= da + (db >> 24);
            done <= 1'b1;
          end
          OP_ARRIVE: begin
            lon <= elon;
            lat <= elat;
            arrived <= 1'b1;
            done <= 1'b1;
          end
          default: ;
        endcase
      end
      if (mphase) begin
        mphase <= 1'b0;
        done <= 1'b1;
        case (cmd.c.dst)
          DST_TA: ta <= qv;
          DST_TB: tb <= qv;
          DST_YR: yr <= qv;
          DST_SQ: sq <= 64'h1000_0000_0000_0000 - prod[63:0];
          DST_P:  p <= prod[47:0];
          DST_DA: da <= prod[49:0];
          DST_DB: db <= prod[49:0];
          default: ;
        endcase
      end
      if (c_done) begin
        done <= 1'b1;
        case (cmd.c.dst)
          DST_P1: begin
            c1 <= clampq(c_x);
            s1 <= clampq(c_y);
          end
          DST_P2: begin
            c2 <= clampq(c_x);
            s2 <= clampq(c_y);
          end
          DST_P3: begin
            cd <= clampq(c_x);
            sd <= clampq(c_y);
          end
          DST_LEN: begin
            len <= lenc & ANG_MASK;
            near <= lenc < NEAR_LEN;
          end
          DST_AZ: begin
            az <= c_z & ANG_MASK;
            arrived <= 1'b0;
          end
          DST_LAT: lat <= latc & ANG_MASK;
          DST_LON: lon <= (slon + c_z) & ANG_MASK;
          default: ;
        endcase
      end
      if (q_done) begin
        q <= q_r;
        done <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/gcp_ctrl.sv
`timescale 1ns / 1ps
module gcp_ctrl
  import gcp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  dp_stat_t             stat,
  output dp_cmd_t              cmd
);

  typedef enum logic [1:0] {IDLE, ISSUE, WAIT, EMIT} state_t;

  state_t          state;
  logic [PC_W-1:0] pc;
  logic            start;
  logic            derived;
  logic            accept, load;
  cmd_t            cur;

  assign cur      = prog(pc);
  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load     = (state == EMIT) && (!m_tvalid || m_tready);

  assign cmd.c       = cur;
  assign cmd.start   = start;
  assign cmd.capture = accept;
  assign cmd.load    = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      pc <= '0;
      start <= 1'b0;
      derived <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      start <= 1'b0;
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (cfg_we && cfg_index < REG_COUNT) derived <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            pc <= derived ? PC_STEP : '0;
            state <= ISSUE;
          end
        end
        ISSUE: begin
          priority case (cur.op)
            OP_BRNEAR: pc <= stat.near ? pc + 1'b1 : PC_FAR;
            OP_JUMP:   pc <= PC_AZ;
            OP_BRPAST: pc <= stat.past ? PC_ARRIVE : pc + 1'b1;
            default: begin
              start <= 1'b1;
              state <= WAIT;
            end
          endcase
        end
        WAIT: begin
          if (stat.done) begin
            if (pc == PC_AZ) derived <= 1'b1;
            if (pc == PC_LON || pc == PC_ARRIVE) begin
              state <= EMIT;
            end else begin
              pc <= pc + 1'b1;
              state <= ISSUE;
            end
          end
        end
        EMIT: begin
          if (load) state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/gcp_checker.sv
`timescale 1ns / 1ps
module gcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // One item at a time: the block is busy right after a transfer in.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item accepted while busy");

  // A result never appears in the cycle after an item is taken.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !$rose(m_tvalid))
    else $error("result too early");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind great_circle_track_position_top gcp_checker u_chk (.*);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the great-circle track position block.
module tb_top;
  import gcp_pkg::*;

  // The run is ended by force if it has not finished after this many cycles.
  localparam int LIMIT_CYCLES = 3000000;
  // Cycles to wait after the last result before the verdict is printed.
  localparam int DRAIN_CYCLES = 600;
  // Length of the one long hold-off on the result side.
  localparam int LONG_HOLD = 4000;
  localparam int RANDOM_PHASES = 30;
  localparam int ITEMS_PER_PHASE = 40;
  localparam logic [31:0] ANGLE_MASK = 32'hFFFFFFFF << (32 - ANGLE_BITS_DEF);
  localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = '1;
  localparam longint QONE_L = 64'sd1073741824;
  localparam longint KINV_L = 64'sh26DD3B6A;
  localparam longint NEAR_L = 64'sd5364662;
  localparam longint FLAT_L = 64'sd684;
  localparam longint SPEED_L = 64'sd31251423;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0] value;
    logic typed;
    logic [31:0] lon;
    logic [31:0] lat;
    logic arrived;
  } row_t;

  typedef struct packed {
    logic [31:0] lon;
    logic [31:0] lat;
    logic arrived;
  } position_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;        // [31:0] cur_lon, [63:32] cur_lat
  logic m_tuser;               // [0] arrived
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  great_circle_track_position_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration and of the derived track.
  logic [31:0] sh_start_lat, sh_start_lon, sh_end_lat, sh_end_lon;
  logic [15:0] sh_speed;
  logic [31:0] trk_azimuth, trk_length;
  logic trk_ready, arrived_flag;

  position_t pending_positions[$];
  int errors = 0;
  int cycles = 0;
  logic quiet = 1'b0;
  logic long_hold_req = 1'b0;

  // A typed expectation travels beside the item that the driver offers; the
  // monitor takes it instead of the predicted one when the transfer happens.
  logic row_typed = 1'b0;
  position_t row_expect;

  logic [31:0] arctan_steps[32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  function automatic longint sx32(input logic [31:0] u);
    return longint'(signed'(u));
  endfunction

  function automatic longint clamp_unit(input longint v);
    return v > QONE_L ? QONE_L : (v < -QONE_L ? -QONE_L : v);
  endfunction

  // Q30 product, rounded toward minus infinity.
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint cos_from_sin(input longint s);
    longint unsigned v, r, b;
    s = clamp_unit(s);
    v = longint'(QONE_L * QONE_L) - longint'(s * s);
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  task automatic cordic_rotate(input logic [31:0] a, output longint c, output longint s);
    logic flip;
    longint x, y, z, dx, dy;
    logic [31:0] shifted;
    shifted = a + 32'h40000000;
    flip = shifted[31];
    if (flip) a = a + 32'h80000000;
    x = KINV_L;
    y = 0;
    z = sx32(a);
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(arctan_steps[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(arctan_steps[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clamp_unit(x);
    s = clamp_unit(y);
  endtask

  function automatic logic [31:0] cordic_vector(input longint y, input longint x);
    logic [31:0] z;
    longint dx, dy;
    z = '0;
    if (y == 0) return x >= 0 ? 32'h0 : 32'h80000000;
    if (x == 0) return y > 0 ? 32'h40000000 : 32'hC0000000;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + arctan_steps[i];
      end else begin
        x = x - dx; y = y + dy; z = z - arctan_steps[i];
      end
    end
    return z;
  endfunction

  task automatic derive_track();
    longint c1, s1, c2, s2, cd, sd, cosd, y, x;
    logic [31:0] dl, len;
    dl = sh_end_lon - sh_start_lon;
    cordic_rotate(sh_start_lat, c1, s1);
    cordic_rotate(sh_end_lat, c2, s2);
    cordic_rotate(dl, cd, sd);
    cosd = clamp_unit(qmul(s1, s2) + qmul(qmul(c1, c2), cd));
    len = cordic_vector(cos_from_sin(cosd), cosd);
    if (len >= 32'hC0000000) len = '0;
    else if (len > 32'h80000000) len = 32'h80000000;
    trk_length = len & ANGLE_MASK;
    // Short tracks take the flat-earth azimuth, biased so it never divides 0 by 0.
    if (longint'({32'b0, len}) < NEAR_L) begin
      y = qmul(sx32(dl), c1);
      x = sx32(sh_end_lat) - sx32(sh_start_lat) + FLAT_L;
    end else begin
      y = qmul(sd, c2);
      x = qmul(c1, s2) - qmul(qmul(s1, c2), cd);
    end
    trk_azimuth = cordic_vector(y, x) & ANGLE_MASK;
    trk_ready = 1'b1;
    arrived_flag = 1'b0;
  endtask

  task automatic predict_position(input logic [31:0] secs, output position_t pos);
    longint t, d, ca, sa, cx, sxv, cf, sf, s2, lat;
    longint unsigned mag, p, travel;
    if (!trk_ready) derive_track();
    t = sx32(secs);
    mag = t < 0 ? -t : t;
    p = longint'(sh_speed) * mag;
    travel = (p >> 24) * SPEED_L + (((p & 64'hFFFFFF) * SPEED_L) >> 24);
    d = t < 0 ? -longint'(travel) : longint'(travel);
    if (d > longint'({32'b0, trk_length})) begin
      arrived_flag = 1'b1;
      pos.lon = sh_end_lon;
      pos.lat = sh_end_lat;
      pos.arrived = 1'b1;
    end else begin
      cordic_rotate(trk_azimuth, ca, sa);
      cordic_rotate(d[31:0], cx, sxv);
      cordic_rotate(sh_start_lat, cf, sf);
      s2 = clamp_unit(qmul(sf, cx) + qmul(qmul(cf, sxv), ca));
      lat = sx32(cordic_vector(s2, cos_from_sin(s2)));
      lat = clamp_unit(lat);
      pos.lat = lat[31:0] & ANGLE_MASK;
      pos.lon = (sh_start_lon + cordic_vector(qmul(qmul(sa, sxv), cf),
                 cx - qmul(sf, s2))) & ANGLE_MASK;
      pos.arrived = arrived_flag;
    end
  endtask

  // Monitor: follows register writes, predicts each accepted item and checks
  // each result transfer against the oldest pending position.
  always @(posedge clk) begin
    position_t pos, got;
    cycles <= cycles + 1;
    if (rst) begin
      sh_start_lat = '0; sh_start_lon = '0; sh_end_lat = '0; sh_end_lon = '0;
      sh_speed = '0; trk_azimuth = '0; trk_length = '0;
      trk_ready = 1'b0; arrived_flag = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_LAT: sh_start_lat = cfg_data;
          REG_START_LON: sh_start_lon = cfg_data;
          REG_END_LAT:   sh_end_lat = cfg_data;
          REG_END_LON:   sh_end_lon = cfg_data;
          REG_SPEED:     sh_speed = cfg_data[15:0];
          default: ;
        endcase
        if (cfg_index < REG_COUNT) trk_ready = 1'b0;
      end
      if (s_tvalid && s_tready) begin
        predict_position(s_tdata, pos);
        pending_positions.insert(pending_positions.size(), row_typed ? row_expect : pos);
      end
      if (m_tvalid && m_tready) begin
        got.lon = m_tdata[31:0];
        got.lat = m_tdata[63:32];
        got.arrived = m_tuser;
        if (pending_positions.size() == 0) begin
          $error("result transfer with no pending position: lon %h lat %h",
                 got.lon, got.lat);
          errors++;
        end else begin
          pos = pending_positions.pop_front();
          if (got.lon !== pos.lon) begin
            $error("cur_lon expected %h actual %h", pos.lon, got.lon);
            errors++;
          end
          if (got.lat !== pos.lat) begin
            $error("cur_lat expected %h actual %h", pos.lat, got.lat);
            errors++;
          end
          if (got.arrived !== pos.arrived) begin
            $error("arrived expected %b actual %b", pos.arrived, got.arrived);
            errors++;
          end
        end
      end
    end
  end

  // Result side: short random hold-offs, and one long hold-off on request that
  // lets the block fill up and push back on its input.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        m_tready = 1'b0;
        hold--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        hold = $urandom_range(0, 2);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Waits until every pending position has arrived and the block has settled.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_positions.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
    @(negedge clk);
    s_tvalid = 1'b0;
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offers one item and returns once its transfer has happened. The caller is
  // at a falling edge; valid stays high into the next item unless a gap is drawn.
  task automatic send_seconds(input logic [31:0] secs, input logic typed,
                              input position_t typed_pos);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = secs;
    row_typed = typed;
    row_expect = typed_pos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    row_typed = 1'b0;
  endtask

  function automatic logic [31:0] random_lat();
    case ($urandom_range(0, 5))
      0: return 32'h40000000;
      1: return 32'hC0000000;
      default: return $urandom_range(0, 32'h80000000) - 32'h40000000;
    endcase
  endfunction

  function automatic logic [31:0] random_seconds();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 200);
      1: v = $urandom_range(0, 20000);
      2: v = $urandom_range(0, 2000000);
      3: v = $urandom_range(0, 200000000);
      default: v = $urandom;
    endcase
    // Backward moves are fewer, but frequent enough to wrap around the globe.
    if ($urandom_range(0, 3) == 0) v = -v;
    return v;
  endfunction

  row_t directed[$];

  function automatic void add_row(input row_t r);
    directed.insert(directed.size(), r);
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
    row_t r;
    r = '{ROW_CFG, index, value, 1'b0, '0, '0, 1'b0};
    return r;
  endfunction

  function automatic row_t item_row(input logic [31:0] secs, input logic typed,
                                    input logic [31:0] lon, input logic [31:0] lat,
                                    input logic arr);
    row_t r;
    r = '{ROW_ITEM, '0, secs, typed, lon, lat, arr};
    return r;
  endfunction

  initial begin
    position_t pos;
    logic [31:0] slat, slon;
    logic was_cfg;

    // Directed part. The reset configuration is used first, at zero speed.
    add_row(item_row(32'h00000000, 1'b0, '0, '0, 1'b0));
    add_row(item_row(32'h7FFFFFFF, 1'b0, '0, '0, 1'b0));
    add_row(item_row(32'h80000000, 1'b0, '0, '0, 1'b0));
    // Pole to pole across the date line at top speed: the longest time is past the end.
    add_row(cfg_row(REG_START_LAT, 32'h40000000));
    add_row(cfg_row(REG_START_LON, 32'h80000000));
    add_row(cfg_row(REG_END_LAT, 32'hC0000000));
    add_row(cfg_row(REG_END_LON, 32'h7FFFFFFF));
    add_row(cfg_row(REG_SPEED, 32'h0000FFFF));
    add_row(item_row(32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF, 32'hC0000000, 1'b1));
    add_row(item_row(32'h00000001, 1'b0, '0, '0, 1'b0));
    add_row(item_row(32'h80000000, 1'b0, '0, '0, 1'b0));
    add_row(item_row(32'hFFFFFFFF, 1'b0, '0, '0, 1'b0));
    // A speed change rederives the track and clears the arrival flag.
    add_row(cfg_row(REG_SPEED, 32'h00000000));
    add_row(item_row(32'd1000, 1'b0, '0, '0, 1'b0));
    // A short hop that takes the flat azimuth.
    add_row(cfg_row(REG_START_LAT, 32'h00000000));
    add_row(cfg_row(REG_START_LON, 32'h00000000));
    add_row(cfg_row(REG_END_LAT, 32'd1000));
    add_row(cfg_row(REG_END_LON, 32'd500));
    add_row(cfg_row(REG_SPEED, 32'd16));
    add_row(item_row(32'd1, 1'b0, '0, '0, 1'b0));
    add_row(item_row(32'h7FFFFFFF, 1'b1, 32'd500, 32'd1000, 1'b1));
    // Writes to unknown registers change nothing and leave the track in place.
    add_row(cfg_row(REG_COUNT, 32'hFFFFFFFF));
    add_row(cfg_row(REG_LAST_INDEX, 32'h12345678));
    add_row(item_row(32'd5, 1'b0, '0, '0, 1'b0));
    // Start equal to end: a zero-length track.
    add_row(cfg_row(REG_END_LAT, 32'h00000000));
    add_row(cfg_row(REG_END_LON, 32'h00000000));
    add_row(item_row(32'd0, 1'b0, '0, '0, 1'b0));
    add_row(item_row(32'hFFFFFFF0, 1'b0, '0, '0, 1'b0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    was_cfg = 1'b1;
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        if (!was_cfg) wait_idle();
        write_reg(directed[i].index, directed[i].value);
        was_cfg = 1'b1;
      end else begin
        pos = '{directed[i].lon, directed[i].lat, directed[i].arrived};
        send_seconds(directed[i].value, directed[i].typed, pos);
        was_cfg = 1'b0;
      end
    end

    // Random phases: a fresh track each time, then a run of items along it.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      if (ph >= RANDOM_PHASES - 4) quiet = 1'b1;
      slat = random_lat();
      slon = $urandom;
      if ($urandom_range(0, 1)) write_reg(REG_START_LAT, slat);
      if ($urandom_range(0, 1)) write_reg(REG_START_LON, slon);
      if ($urandom_range(0, 3) == 0) begin
        // Short hop around the start point.
        write_reg(REG_END_LAT, slat + $urandom_range(0, 4000000) - 2000000);
        write_reg(REG_END_LON, slon + $urandom_range(0, 4000000) - 2000000);
      end else begin
        write_reg(REG_END_LAT, random_lat());
        write_reg(REG_END_LON, $urandom);
      end
      case ($urandom_range(0, 4))
        0: write_reg(REG_SPEED, 32'd0);
        1: write_reg(REG_SPEED, 32'h0000FFFF);
        default: write_reg(REG_SPEED, $urandom);
      endcase
      if ($urandom_range(0, 5) == 0) begin
        write_reg(CFG_IDX_W'(REG_COUNT + $urandom_range(0, 2)), $urandom);
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 3 && k == 5) long_hold_req = 1'b1;
        send_seconds(random_seconds(), 1'b0, pos);
      end
    end

    s_tvalid = 1'b0;
    while (pending_positions.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending_positions.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
